[hw/rtl/pds_pkg.sv]
package pds_pkg;

   localparam int CoordWidth    = 24;
   localparam int DiffWidth     = CoordWidth + 1;
   localparam int ProdWidth     = 2 * DiffWidth;
   localparam int SumWidth      = ProdWidth + 2;
   localparam int RootWidth     = ProdWidth / 2;
   localparam int DistWidth     = 26;
   localparam int FracBits      = 24;
   localparam int TWidth        = FracBits + 1;
   localparam int ReqDataWidth  = 9 * CoordWidth;
   localparam int RspFieldBits  = 2 * DistWidth + 3 * CoordWidth;
   localparam int RspDataWidth  = ((RspFieldBits + 7) / 8) * 8;
   localparam int RegionWidth   = 2;

   typedef enum logic [RegionWidth-1:0] {
      REGION_INSIDE = 2'd0,
      REGION_BEFORE = 2'd1,
      REGION_PAST   = 2'd2
   } region_type;

endpackage

[hw/rtl/pds_div.sv]
module pds_div #(
   parameter int NumWidth  = 50,
   parameter int DenWidth  = 25,
   parameter int QuoWidth  = 26,
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [NumWidth-1:0]  in_num,
   input  logic [DenWidth-1:0]  in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [QuoWidth-1:0]  out_quo,
   output logic [SideWidth-1:0] out_side
);

   localparam int RemWidth = DenWidth + QuoWidth;

   logic                 valid_ff [QuoWidth];
   logic [RemWidth-1:0]  rem_ff   [QuoWidth];
   logic [DenWidth-1:0]  den_ff   [QuoWidth];
   logic [QuoWidth-1:0]  quo_ff   [QuoWidth];
   logic [SideWidth-1:0] side_ff  [QuoWidth];

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QuoWidth; k++) begin : g_step
      localparam int Bit = QuoWidth - 1 - k;
      logic                 valid_c;
      logic [RemWidth-1:0]  rem_c;
      logic [RemWidth-1:0]  trial;
      logic [RemWidth-1:0]  rem_in;
      logic [DenWidth-1:0]  den_c;
      logic [QuoWidth-1:0]  quo_c;
      logic [QuoWidth-1:0]  quo_in;
      logic [SideWidth-1:0] side_c;

      if (k == 0) begin : g_head
         assign valid_c = in_valid;
         assign rem_c   = RemWidth'(in_num);
         assign den_c   = in_den;
         assign quo_c   = '0;
         assign side_c  = in_side;
      end else begin : g_body
         assign valid_c = valid_ff[k-1];
         assign rem_c   = rem_ff[k-1];
         assign den_c   = den_ff[k-1];
         assign quo_c   = quo_ff[k-1];
         assign side_c  = side_ff[k-1];
      end

      assign trial = RemWidth'(den_c) << Bit;

      always_comb begin
         if (rem_c >= trial) begin
            rem_in = rem_c - trial;
            quo_in = quo_c | (QuoWidth'(1) << Bit);
         end else begin
            rem_in = rem_c;
            quo_in = quo_c;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_c;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_c;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_c;
         end
      end
   end

   assign out_valid = valid_ff[QuoWidth-1];
   assign out_quo   = quo_ff[QuoWidth-1];
   assign out_side  = side_ff[QuoWidth-1];

endmodule

[hw/rtl/pds_isqrt.sv]
module pds_isqrt #(
   parameter int RadWidth  = 50,
   parameter int SideWidth = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [RadWidth-1:0]     in_rad,
   input  logic [SideWidth-1:0]    in_side,
   output logic                    out_valid,
   output logic [RadWidth/2-1:0]   out_root,
   output logic [SideWidth-1:0]    out_side
);

   localparam int RootBits = RadWidth / 2;
   localparam int RemWidth = RadWidth + 2;

   logic                 valid_ff [RootBits];
   logic [RemWidth-1:0]  rem_ff   [RootBits];
   logic [RootBits-1:0]  root_ff  [RootBits];
   logic [SideWidth-1:0] side_ff  [RootBits];

   // one root bit per stage; rem holds radicand minus root squared
   for (genvar k = 0; k < RootBits; k++) begin : g_step
      localparam int Bit = RootBits - 1 - k;
      logic                 valid_c;
      logic [RemWidth-1:0]  rem_c;
      logic [RemWidth-1:0]  trial;
      logic [RemWidth-1:0]  rem_in;
      logic [RootBits-1:0]  root_c;
      logic [RootBits-1:0]  root_in;
      logic [SideWidth-1:0] side_c;

      if (k == 0) begin : g_head
         assign valid_c = in_valid;
         assign rem_c   = RemWidth'(in_rad);
         assign root_c  = '0;
         assign side_c  = in_side;
      end else begin : g_body
         assign valid_c = valid_ff[k-1];
         assign rem_c   = rem_ff[k-1];
         assign root_c  = root_ff[k-1];
         assign side_c  = side_ff[k-1];
      end

      assign trial = (RemWidth'(root_c) << (Bit + 1)) + (RemWidth'(1) << (2 * Bit));

      always_comb begin
         if (rem_c >= trial) begin
            rem_in  = rem_c - trial;
            root_in = root_c | (RootBits'(1) << Bit);
         end else begin
            rem_in  = rem_c;
            root_in = root_c;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_c;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_c;
         end
      end
   end

   assign out_valid = valid_ff[RootBits-1];
   assign out_root  = root_ff[RootBits-1];
   assign out_side  = side_ff[RootBits-1];

endmodule

[hw/rtl/point_to_segment_distance.sv]
// Throughput: one item per cycle while the output buffer is not full; the chain is
// three setup stages, a 25-stage projection divider beside a 25-stage length root,
// a 26-stage divider for the distance along, four foot/distance stages, a 25-stage
// root and a 2-entry output buffer.
// Reset is synchronous, active high; it clears all valid bits and the output buffer.
module point_to_segment_distance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
   input  logic [pds_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // signed_distance, along_segment, foot_x, foot_y, foot_z, zero pad
   output logic [pds_pkg::RspDataWidth-1:0] rsp_tdata,
   // region
   output logic [pds_pkg::RegionWidth-1:0]  rsp_tuser
);

   import pds_pkg::*;

   localparam int FootWide = CoordWidth + 3;
   localparam int SlotWidth = RspDataWidth + RegionWidth;

   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type [2:0] pnt;
      coord_type [2:0] sta;
      coord_type [2:0] fin;
   } geom_type;

   typedef struct packed {
      geom_type   geom;
      region_type region;
      logic       len2_zero;
      logic       dot_neg;
   } side1_type;

   typedef struct packed {
      geom_type              geom;
      region_type            region;
      logic                  len2_zero;
      logic                  dot_neg;
      logic [TWidth-1:0]     t;
   } side2_type;

   typedef struct packed {
      logic [DistWidth-1:0]  along;
      coord_type [2:0]       foot;
      region_type            region;
   } side3_type;

   localparam logic [DistWidth-1:0] NegMag = {1'b1, {(DistWidth-1){1'b0}}};
   localparam logic [DistWidth-1:0] PosMax = {1'b0, {(DistWidth-1){1'b1}}};
   localparam logic [ProdWidth-1:0] Half   = ProdWidth'(1) << (FracBits - 1);

   logic       en;
   logic [1:0] count_ff;

   assign en         = (count_ff != 2'd2);
   assign req_tready = en;

   // stage 1: differences
   geom_type g_req;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_req.pnt[i] = req_tdata[CoordWidth*i +: CoordWidth];
         g_req.sta[i] = req_tdata[CoordWidth*(i+3) +: CoordWidth];
         g_req.fin[i] = req_tdata[CoordWidth*(i+6) +: CoordWidth];
      end
   end

   logic                        v1_ff;
   geom_type                    g1_ff;
   logic signed [DiffWidth-1:0] d1_ff [3];
   logic signed [DiffWidth-1:0] t1_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         g1_ff <= g_req;
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= DiffWidth'($signed(g_req.fin[i])) - DiffWidth'($signed(g_req.sta[i]));
            t1_ff[i] <= DiffWidth'($signed(g_req.pnt[i])) - DiffWidth'($signed(g_req.sta[i]));
         end
      end
   end

   // stage 2: products
   logic                        v2_ff;
   geom_type                    g2_ff;
   logic signed [ProdWidth-1:0] dd2_ff [3];
   logic signed [ProdWidth-1:0] dt2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         g2_ff <= g1_ff;
         for (int i = 0; i < 3; i++) begin
            dd2_ff[i] <= ProdWidth'(d1_ff[i]) * ProdWidth'(d1_ff[i]);
            dt2_ff[i] <= ProdWidth'(d1_ff[i]) * ProdWidth'(t1_ff[i]);
         end
      end
   end

   // stage 3: dot, squared length, region
   logic signed [SumWidth-1:0]  dot_c;
   logic signed [SumWidth-1:0]  len2_sum;
   logic signed [SumWidth-1:0]  dot_abs;
   logic [ProdWidth-1:0]        len2_c;
   logic [ProdWidth-1:0]        dot_mag_c;
   side1_type                   s1_c;

   always_comb begin
      dot_c    = '0;
      len2_sum = '0;
      for (int i = 0; i < 3; i++) begin
         dot_c    = dot_c + SumWidth'(dt2_ff[i]);
         len2_sum = len2_sum + SumWidth'(dd2_ff[i]);
      end
      dot_abs   = dot_c[SumWidth-1] ? -dot_c : dot_c;
      dot_mag_c = dot_abs[ProdWidth-1:0];
      len2_c    = len2_sum[ProdWidth-1:0];
      s1_c.geom      = g2_ff;
      s1_c.len2_zero = (len2_c == '0);
      s1_c.dot_neg   = dot_c[SumWidth-1];
      priority if (dot_c[SumWidth-1]) begin
         s1_c.region = REGION_BEFORE;
      end else if (dot_mag_c > len2_c) begin
         s1_c.region = REGION_PAST;
      end else begin
         s1_c.region = REGION_INSIDE;
      end
   end

   logic                 v3_ff;
   side1_type            s1_ff;
   logic [ProdWidth-1:0] len2_ff;
   logic [ProdWidth-1:0] dot_mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         s1_ff      <= s1_c;
         len2_ff    <= len2_c;
         dot_mag_ff <= dot_mag_c;
      end
   end

   // projection fraction t = dot * 2^24 / len2, only needed inside
   logic [ProdWidth+FracBits-1:0] tnum;
   assign tnum = (s1_ff.region == REGION_INSIDE) ? {dot_mag_ff, FracBits'(0)} : '0;

   logic                   tdiv_valid;
   logic [TWidth-1:0]      tq;
   side1_type              s1_out;

   pds_div #(
      .NumWidth  (ProdWidth + FracBits),
      .DenWidth  (ProdWidth),
      .QuoWidth  (TWidth),
      .SideWidth ($bits(side1_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_num    (tnum),
      .in_den    (len2_ff),
      .in_side   (s1_ff),
      .out_valid (tdiv_valid),
      .out_quo   (tq),
      .out_side  (s1_out)
   );

   logic                  lsq_valid;
   logic [RootWidth-1:0]  lq;
   logic [ProdWidth-1:0]  dot_mag_out;

   pds_isqrt #(
      .RadWidth  (ProdWidth),
      .SideWidth (ProdWidth)
   ) u_len_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (len2_ff),
      .in_side   (dot_mag_ff),
      .out_valid (lsq_valid),
      .out_root  (lq),
      .out_side  (dot_mag_out)
   );

   // distance along = |dot| / floor(sqrt(len2))
   side2_type s2_c;
   always_comb begin
      s2_c.geom      = s1_out.geom;
      s2_c.region    = s1_out.region;
      s2_c.len2_zero = s1_out.len2_zero;
      s2_c.dot_neg   = s1_out.dot_neg;
      s2_c.t         = s1_out.len2_zero ? '0 : tq;
   end

   logic                 adiv_valid;
   logic [DistWidth-1:0] aq;
   side2_type            s2_out;

   pds_div #(
      .NumWidth  (ProdWidth),
      .DenWidth  (RootWidth),
      .QuoWidth  (DistWidth),
      .SideWidth ($bits(side2_type))
   ) u_adiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tdiv_valid & lsq_valid),
      .in_num    (dot_mag_out),
      .in_den    (lq),
      .in_side   (s2_c),
      .out_valid (adiv_valid),
      .out_quo   (aq),
      .out_side  (s2_out)
   );

   // stage F1: saturate along, scale direction by t
   logic [DistWidth-1:0]        along_c;
   logic signed [DiffWidth-1:0] dvec_c [3];
   logic [DiffWidth-1:0]        dmag_c [3];

   always_comb begin
      priority if (s2_out.len2_zero) begin
         along_c = '0;
      end else if (s2_out.dot_neg) begin
         along_c = (aq > NegMag) ? NegMag : -aq;
      end else begin
         along_c = (aq > PosMax) ? PosMax : aq;
      end
      for (int i = 0; i < 3; i++) begin
         dvec_c[i] = DiffWidth'($signed(s2_out.geom.fin[i]))
                   - DiffWidth'($signed(s2_out.geom.sta[i]));
         dmag_c[i] = dvec_c[i][DiffWidth-1] ? -dvec_c[i] : dvec_c[i];
      end
   end

   logic                 v5_ff;
   geom_type             g5_ff;
   region_type           region5_ff;
   logic [DistWidth-1:0] along5_ff;
   logic [ProdWidth-1:0] prod5_ff [3];
   logic                 dneg5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= adiv_valid;
      end
      if (en) begin
         g5_ff      <= s2_out.geom;
         region5_ff <= s2_out.region;
         along5_ff  <= along_c;
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i] <= ProdWidth'(dmag_c[i]) * ProdWidth'(s2_out.t);
            dneg5_ff[i] <= dvec_c[i][DiffWidth-1];
         end
      end
   end

   // stage F2: round the offset and saturate the foot, or take the end point outside
   logic [ProdWidth-1:0]       rnd_c  [3];
   logic signed [FootWide-1:0] fsum_c [3];
   coord_type [2:0]            foot_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_c[i] = prod5_ff[i] + Half;
         if (dneg5_ff[i]) begin
            fsum_c[i] = FootWide'($signed(g5_ff.sta[i]))
                      - $signed(FootWide'(rnd_c[i][ProdWidth-1:FracBits]));
         end else begin
            fsum_c[i] = FootWide'($signed(g5_ff.sta[i]))
                      + $signed(FootWide'(rnd_c[i][ProdWidth-1:FracBits]));
         end
         unique case (region5_ff)
            REGION_BEFORE: foot_c[i] = g5_ff.sta[i];
            REGION_PAST:   foot_c[i] = g5_ff.fin[i];
            default: begin
               priority if (fsum_c[i] > FootWide'($signed({1'b0, {(CoordWidth-1){1'b1}}}))) begin
                  foot_c[i] = {1'b0, {(CoordWidth-1){1'b1}}};
               end else if (fsum_c[i] < FootWide'($signed({1'b1, {(CoordWidth-1){1'b0}}}))) begin
                  foot_c[i] = {1'b1, {(CoordWidth-1){1'b0}}};
               end else begin
                  foot_c[i] = fsum_c[i][CoordWidth-1:0];
               end
            end
         endcase
      end
   end

   logic            v6_ff;
   coord_type [2:0] pnt6_ff;
   side3_type       s3_6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
      if (en) begin
         pnt6_ff        <= g5_ff.pnt;
         s3_6_ff.along  <= along5_ff;
         s3_6_ff.foot   <= foot_c;
         s3_6_ff.region <= region5_ff;
      end
   end

   // stage F3: squared offsets from the foot
   logic signed [DiffWidth-1:0] off_c [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_c[i] = DiffWidth'($signed(pnt6_ff[i])) - DiffWidth'($signed(s3_6_ff.foot[i]));
      end
   end

   logic                        v7_ff;
   side3_type                   s3_7_ff;
   logic signed [ProdWidth-1:0] sq7_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
      if (en) begin
         s3_7_ff <= s3_6_ff;
         for (int i = 0; i < 3; i++) begin
            sq7_ff[i] <= ProdWidth'(off_c[i]) * ProdWidth'(off_c[i]);
         end
      end
   end

   // stage F4: sum of squares
   logic signed [SumWidth-1:0] sqsum_c;

   always_comb begin
      sqsum_c = '0;
      for (int i = 0; i < 3; i++) begin
         sqsum_c = sqsum_c + SumWidth'(sq7_ff[i]);
      end
   end

   logic                 v8_ff;
   side3_type            s3_8_ff;
   logic [ProdWidth-1:0] sqsum8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
      if (en) begin
         s3_8_ff   <= s3_7_ff;
         sqsum8_ff <= sqsum_c[ProdWidth-1:0];
      end
   end

   logic                 dsq_valid;
   logic [RootWidth-1:0] mag;
   side3_type            s3_out;

   pds_isqrt #(
      .RadWidth  (ProdWidth),
      .SideWidth ($bits(side3_type))
   ) u_dist_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v8_ff),
      .in_rad    (sqsum8_ff),
      .in_side   (s3_8_ff),
      .out_valid (dsq_valid),
      .out_root  (mag),
      .out_side  (s3_out)
   );

   // sign the distance: the root never exceeds the positive limit
   logic [DistWidth-1:0] mag_wide;
   logic [DistWidth-1:0] dist_c;
   logic [SlotWidth-1:0] slot_c;

   assign mag_wide = DistWidth'(mag);
   assign dist_c   = (s3_out.region == REGION_INSIDE) ? mag_wide : -mag_wide;
   assign slot_c   = {s3_out.region, (RspDataWidth - RspFieldBits)'(0),
                      s3_out.foot[2], s3_out.foot[1], s3_out.foot[0],
                      s3_out.along, dist_c};

   // output buffer, two items deep
   logic                 push;
   logic                 pop;
   logic                 rd_ff;
   logic                 wr_ff;
   logic [SlotWidth-1:0] slot_ff [2];

   assign push = en & dsq_valid;
   assign pop  = rsp_tvalid & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_ff + 2'(push) - 2'(pop);
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
      if (push) begin
         slot_ff[wr_ff] <= slot_c;
      end
   end

   assign rsp_tvalid             = (count_ff != 2'd0);
   assign {rsp_tuser, rsp_tdata} = slot_ff[rd_ff];

endmodule

[hw/rtl/pds_checker.sv]
module pds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pds_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic [pds_pkg::RegionWidth-1:0]  rsp_tuser
);

   import pds_pkg::*;

   logic signed [DistWidth-1:0] sdist;
   logic signed [DistWidth-1:0] along;

   assign sdist = rsp_tdata[DistWidth-1:0];
   assign along = rsp_tdata[2*DistWidth-1:DistWidth];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_inside_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REGION_INSIDE |-> !sdist[DistWidth-1])
      else $error("negative distance inside the segment");

   a_outside_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != REGION_INSIDE |-> sdist[DistWidth-1] || sdist == '0)
      else $error("positive distance outside the segment");

   a_before_along: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REGION_BEFORE |-> along[DistWidth-1] || along == '0)
      else $error("positive projection before the start");

endmodule

bind point_to_segment_distance pds_checker u_pds_checker (.*);

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pds_pkg::*;

   typedef struct {
      logic signed [25:0] signed_distance;
      logic signed [25:0] along_segment;
      logic signed [23:0] foot_x;
      logic signed [23:0] foot_y;
      logic signed [23:0] foot_z;
      region_type         region;
   } seg_result_type;

   class distance_scoreboard;
      seg_result_type pending[$];
      int             errors = 0;

      function automatic longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function automatic longint unsigned mag_of(longint v);
         return v < 0 ? longint'(-v) : longint'(v);
      endfunction

      function automatic longint clamp24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function automatic void note_query(logic [ReqDataWidth-1:0] data);
         longint p[3], s[3], e[3], d[3], foot[3];
         longint dot, along, sdist;
         longint unsigned len2, lq, q, t, r, m, acc, mag;
         seg_result_type res;
         dot = 0;
         len2 = 0;
         along = 0;
         for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(data[i*24 +: 24]));
            s[i] = longint'($signed(data[(3+i)*24 +: 24]));
            e[i] = longint'($signed(data[(6+i)*24 +: 24]));
            d[i] = e[i] - s[i];
            dot += d[i] * (p[i] - s[i]);
            len2 += mag_of(d[i]) * mag_of(d[i]);
         end
         if (len2 != 0) begin
            lq = int_sqrt(len2);
            q = mag_of(dot) / lq;
            if (dot < 0) along = q > 33554432 ? -33554432 : -longint'(q);
            else along = q > 33554431 ? 33554431 : longint'(q);
         end
         if (dot < 0) begin
            res.region = REGION_BEFORE;
            foot = s;
         end else if (unsigned'(dot) > len2) begin
            res.region = REGION_PAST;
            foot = e;
         end else begin
            res.region = REGION_INSIDE;
            t = 0;
            r = dot;
            if (len2 != 0) begin
               if (r >= len2) begin
                  r -= len2;
                  t = 1;
               end
               for (int i = 0; i < 24; i++) begin
                  r <<= 1;
                  t <<= 1;
                  if (r >= len2) begin
                     r -= len2;
                     t |= 1;
                  end
               end
            end
            for (int i = 0; i < 3; i++) begin
               m = (mag_of(d[i]) * t + (64'd1 << 23)) >> 24;
               foot[i] = clamp24(d[i] < 0 ? s[i] - longint'(m) : s[i] + longint'(m));
            end
         end
         acc = 0;
         for (int i = 0; i < 3; i++) acc += mag_of(p[i] - foot[i]) * mag_of(p[i] - foot[i]);
         mag = int_sqrt(acc);
         if (res.region == REGION_INSIDE) sdist = mag > 33554431 ? 33554431 : longint'(mag);
         else sdist = mag > 33554432 ? -33554432 : -longint'(mag);
         res.signed_distance = sdist[25:0];
         res.along_segment = along[25:0];
         res.foot_x = foot[0][23:0];
         res.foot_y = foot[1][23:0];
         res.foot_z = foot[2][23:0];
         pending = {pending, res};
      endfunction

      function automatic void check_result(logic [RspDataWidth-1:0] data,
                                           logic [RegionWidth-1:0] user);
         seg_result_type x;
         if (pending.size() == 0) begin
            $error("unexpected result item");
            errors++;
            return;
         end
         x = pending.pop_front();
         if (data[25:0] !== x.signed_distance) begin
            $error("signed_distance exp %0d got %0d", x.signed_distance, $signed(data[25:0]));
            errors++;
         end
         if (data[51:26] !== x.along_segment) begin
            $error("along_segment exp %0d got %0d", x.along_segment, $signed(data[51:26]));
            errors++;
         end
         if (data[75:52] !== x.foot_x) begin
            $error("foot_x exp %0d got %0d", x.foot_x, $signed(data[75:52]));
            errors++;
         end
         if (data[99:76] !== x.foot_y) begin
            $error("foot_y exp %0d got %0d", x.foot_y, $signed(data[99:76]));
            errors++;
         end
         if (data[123:100] !== x.foot_z) begin
            $error("foot_z exp %0d got %0d", x.foot_z, $signed(data[123:100]));
            errors++;
         end
         if (user !== x.region) begin
            $error("region exp %0d got %0d", x.region, user);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [RegionWidth-1:0] rsp_tuser;
   bit quiet = 0;
   distance_scoreboard board = new();

   point_to_segment_distance u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_query(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // receiver: random stall bursts, none at the end
   initial begin
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   task automatic send_query(logic [ReqDataWidth-1:0] data);
      req_tdata <= data;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   function automatic logic [23:0] rand_coord(int span);
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   function automatic logic [ReqDataWidth-1:0] pack9(longint c[9]);
      logic [ReqDataWidth-1:0] v;
      for (int i = 0; i < 9; i++) v[i*24 +: 24] = c[i][23:0];
      return v;
   endfunction

   initial begin
      logic [ReqDataWidth-1:0] v;
      longint c[9];
      int span;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: zero-length, before, past, at ends, full-scale extremes
      c = '{100, 200, 300, 0, 0, 0, 0, 0, 0};                  send_query(pack9(c));
      c = '{-500, 0, 0, 0, 0, 0, 1000, 0, 0};                  send_query(pack9(c));
      c = '{1500, 30, 0, 0, 0, 0, 1000, 0, 0};                 send_query(pack9(c));
      c = '{0, 77, 0, 0, 0, 0, 1000, 0, 0};                    send_query(pack9(c));
      c = '{1000, 77, 9, 0, 0, 0, 1000, 0, 0};                 send_query(pack9(c));
      c = '{300, 400, -50, 0, 0, 0, 1000, 1000, 1000};         send_query(pack9(c));
      c = '{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
            -8388608, -8388608, -8388608};                      send_query(pack9(c));
      c = '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
            -8388608, -8388608, -8388608};                      send_query(pack9(c));
      c = '{8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
            8388607, -8388608, 8388607};                        send_query(pack9(c));
      c = '{0, 8388607, 0, -8388608, 0, 0, 8388607, 0, 0};     send_query(pack9(c));
      c = '{3, -7, 2, 1, 1, 1, 2, 1, 1};                       send_query(pack9(c));
      c = '{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
            8388607, -8388608, 8388607};                        send_query(pack9(c));
      c = '{5, 5, 5, -3, 4, 8, 9, -2, 6};                      send_query(pack9(c));
      for (int k = 0; k < 1500; k++) begin
         if (k == 700) begin
            // hold off until the pipeline drains
            req_tvalid <= 0;
            while (board.pending.size() != 0) @(negedge clock);
         end
         if (k == 1300) quiet = 1;
         span = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(1, 4000);
         for (int i = 0; i < 9; i++) v[i*24 +: 24] = rand_coord(span);
         if ($urandom_range(0, 19) == 0) v[215:144] = v[143:72];
         send_query(v);
         sender_gap();
      end
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (board.errors == 0) $display("point_to_segment_distance test passed");
      else $display("point_to_segment_distance test failed");
      $finish;
   end

   initial begin
      #3ms;
      $display("point_to_segment_distance test failed");
      $finish;
   end
endmodule
